>>> src/cpp_pkg.sv
// ----------------------------------------------------------------------------
// Conic point projection package
// Shared constants, register indexes and transaction types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

  // Coordinate width of every coordinate field and centre register.
  localparam int unsigned CoordW = 32;

  // APB address width and data width.
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (word address bits of paddr).
  typedef enum logic [1:0] {
    RegCenterX = 2'd0,
    RegCenterY = 2'd1,
    RegCenterZ = 2'd2
  } reg_idx_e;

  // Input transaction.
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  // Output transaction.
  typedef struct packed {
    logic signed [CoordW-1:0] proj_x;
    logic signed [CoordW-1:0] proj_y;
    logic signed [CoordW-1:0] proj_z;
    logic                     div_fault;
  } proj_t;

endpackage

`default_nettype wire

>>> src/cpp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Decides one bit of the integer square root and hands the partial root,
// the remaining radicand and the side data to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpp_sqrt_cell #(
  parameter int unsigned W  = 32,
  parameter int unsigned B  = 0,
  parameter int unsigned PW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*W+3:0]  rem_i,
  input  wire logic [W+1:0]    root_i,
  input  wire logic [PW-1:0]   side_i,
  output logic                 valid_o,
  output logic [2*W+3:0]       rem_o,
  output logic [W+1:0]         root_o,
  output logic [PW-1:0]        side_o
);

  localparam int unsigned SW = 2 * W + 4;

  logic [SW-1:0] trial;
  logic          take;
  logic [SW-1:0] rem_d;
  logic [W+1:0]  root_d;

  // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B).
  always_comb begin
    trial  = ({{(SW-W-2){1'b0}}, root_i} << (B + 1)) + ({{(SW-1){1'b0}}, 1'b1} << (2 * B));
    take   = (trial <= rem_i);
    rem_d  = take ? rem_i - trial : rem_i;
    root_d = take ? (root_i | ({{(W+1){1'b0}}, 1'b1} << B)) : root_i;
  end

  // Valid flag is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

>>> src/cpp_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// Produces one quotient bit for the x and the y lane by restoring division
// and hands the remainders and partial quotients to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpp_div_cell #(
  parameter int unsigned W  = 32,
  parameter int unsigned I  = 0,
  parameter int unsigned PW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [W+1:0]    dv_i,
  input  wire logic [2*W+1:0]  num_x_i,
  input  wire logic [2*W+1:0]  num_y_i,
  input  wire logic [W+1:0]    rem_x_i,
  input  wire logic [W+1:0]    rem_y_i,
  input  wire logic [2*W+1:0]  quo_x_i,
  input  wire logic [2*W+1:0]  quo_y_i,
  input  wire logic [PW-1:0]   side_i,
  output logic                 valid_o,
  output logic [W+1:0]         dv_o,
  output logic [2*W+1:0]       num_x_o,
  output logic [2*W+1:0]       num_y_o,
  output logic [W+1:0]         rem_x_o,
  output logic [W+1:0]         rem_y_o,
  output logic [2*W+1:0]       quo_x_o,
  output logic [2*W+1:0]       quo_y_o,
  output logic [PW-1:0]        side_o
);

  logic [W+2:0]   sh_x, sh_y;
  logic           ge_x, ge_y;
  logic [W+2:0]   nr_x, nr_y;
  logic [2*W+1:0] qd_x, qd_y;

  // Bring down the next numerator bit and try to subtract the divisor.
  always_comb begin
    sh_x = {rem_x_i, num_x_i[I]};
    sh_y = {rem_y_i, num_y_i[I]};
    ge_x = (sh_x >= {1'b0, dv_i});
    ge_y = (sh_y >= {1'b0, dv_i});
    nr_x = ge_x ? sh_x - {1'b0, dv_i} : sh_x;
    nr_y = ge_y ? sh_y - {1'b0, dv_i} : sh_y;
    qd_x = quo_x_i;
    qd_y = quo_y_i;
    qd_x[I] = ge_x;
    qd_y[I] = ge_y;
  end

  // Valid flag is control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Payload registers; the remainder always stays below the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_o    <= dv_i;
      num_x_o <= num_x_i;
      num_y_o <= num_y_i;
      rem_x_o <= nr_x[W+1:0];
      rem_y_o <= nr_y[W+1:0];
      quo_x_o <= qd_x;
      quo_y_o <= qd_y;
      side_o  <= side_i;
    end
  end

endmodule

`default_nettype wire

>>> src/conic_point_projection_top.sv
// ----------------------------------------------------------------------------
// Conic point projection, top level
// Projects each point through a cone around the configured centre.
// ----------------------------------------------------------------------------
// The block accepts one point per clock cycle while no result is stalled at
// the output and returns one result per point, in order. The pipeline runs
// through an offset stage, a squaring stage and a sum stage, one square-root
// cell per root bit, a multiply stage, one divider cell per quotient bit and
// the output register. The whole pipeline moves together, so it holds while
// a finished result is stalled at the output. Centre registers are written
// over APB at byte addresses 0, 4 and 8 and should only change while no
// point is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conic_point_projection_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Point input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire cpp_pkg::point_t              in_data_i,
  // Result output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output cpp_pkg::proj_t                    out_data_o,
  // APB configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cpp_pkg::AddrW-1:0]    paddr,
  input  wire logic [cpp_pkg::DataW-1:0]    pwdata,
  output logic [cpp_pkg::DataW-1:0]         prdata,
  output logic                              pready
);

  localparam int unsigned W   = cpp_pkg::CoordW;
  localparam int unsigned SW  = 2 * W + 4;
  localparam int unsigned NSQ = W + 2;
  localparam int unsigned NW  = 2 * W + 2;
  // Side data through the root cells: mag x, mag y, sign x, sign y, c, z.
  localparam int unsigned PS  = 4 * W + 4;
  // Side data through the divider cells: neg x, neg y, fault, z.
  localparam int unsigned PD  = W + 3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [W-1:0] cx_q, cy_q, cz_q;
  logic                wr_en;
  cpp_pkg::reg_idx_e   rd_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign rd_idx = cpp_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
    end else if (wr_en && (paddr[1:0] == 2'b00)) begin
      case (rd_idx)
        cpp_pkg::RegCenterX: cx_q <= pwdata[W-1:0];
        cpp_pkg::RegCenterY: cy_q <= pwdata[W-1:0];
        cpp_pkg::RegCenterZ: cz_q <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (rd_idx)
      cpp_pkg::RegCenterX: prdata = cx_q;
      cpp_pkg::RegCenterY: prdata = cy_q;
      cpp_pkg::RegCenterZ: prdata = cz_q;
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline enable: everything advances unless a result is held up.
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Offset stage: offsets from the centre, their magnitudes and the scale.
  // --------------------------------------------------------------------------
  logic signed [W:0] dx, dy, dz;
  logic              va_q;
  logic [W:0]        mx_q, my_q, mz_q;
  logic              sx_q, sy_q;
  logic [W-1:0]      c_q, za_q;

  always_comb begin
    dx = {in_data_i.point_x[W-1], in_data_i.point_x} - {cx_q[W-1], cx_q};
    dy = {in_data_i.point_y[W-1], in_data_i.point_y} - {cy_q[W-1], cy_q};
    dz = {in_data_i.point_z[W-1], in_data_i.point_z} - {cz_q[W-1], cz_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= dx[W] ? -dx : dx;
      my_q <= dy[W] ? -dy : dy;
      mz_q <= dz[W] ? -dz : dz;
      sx_q <= dx[W];
      sy_q <= dy[W];
      c_q  <= (cx_q != '0) ? cx_q : ((cy_q != '0) ? cy_q : cz_q);
      za_q <= in_data_i.point_z;
    end
  end

  // --------------------------------------------------------------------------
  // Squaring stage.
  // --------------------------------------------------------------------------
  logic            vb_q;
  logic [NW-1:0]   qx_q, qy_q, qz_q;
  logic [PS-1:0]   sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= mx_q * mx_q;
      qy_q <= my_q * my_q;
      qz_q <= mz_q * mz_q;
      sb_q <= {mx_q, my_q, sx_q, sy_q, c_q, za_q};
    end
  end

  // --------------------------------------------------------------------------
  // Sum stage.
  // --------------------------------------------------------------------------
  logic          vc_q;
  logic [SW-1:0] sum_q;
  logic [PS-1:0] sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= {2'b00, qx_q} + {2'b00, qy_q} + {2'b00, qz_q};
      sc_q  <= sb_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root chain, most significant root bit first.
  // --------------------------------------------------------------------------
  logic          sq_v    [NSQ+1];
  logic [SW-1:0] sq_rem  [NSQ+1];
  logic [W+1:0]  sq_root [NSQ+1];
  logic [PS-1:0] sq_side [NSQ+1];

  assign sq_v[0]    = vc_q;
  assign sq_rem[0]  = sum_q;
  assign sq_root[0] = '0;
  assign sq_side[0] = sc_q;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    cpp_sqrt_cell #(
      .W  (W),
      .B  (NSQ - 1 - k),
      .PW (PS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_v[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Multiply stage: numerators d*|delta| and the divisor |d + c|.
  // --------------------------------------------------------------------------
  logic [W:0]        d_w, smx, smy;
  logic              ssx, ssy;
  logic [W-1:0]      sc_w, sz_w;
  logic signed [W+2:0] den;
  logic [W+2:0]      mden;

  logic              vd_q;
  logic [NW-1:0]     nx_q, ny_q;
  logic [W+1:0]      dv_q;
  logic [PD-1:0]     sd_q;

  always_comb begin
    d_w = sq_root[NSQ][W:0];
    {smx, smy, ssx, ssy, sc_w, sz_w} = sq_side[NSQ];
    den  = {2'b00, d_w} + {{3{sc_w[W-1]}}, sc_w};
    mden = den[W+2] ? (-den) : den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= sq_v[NSQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= d_w * smx;
      ny_q <= d_w * smy;
      dv_q <= mden[W+1:0];
      sd_q <= {ssx ^ den[W+2], ssy ^ den[W+2], (den == '0), sz_w};
    end
  end

  // --------------------------------------------------------------------------
  // Divider chain, most significant quotient bit first.
  // --------------------------------------------------------------------------
  logic          dc_v   [NW+1];
  logic [W+1:0]  dc_dv  [NW+1];
  logic [NW-1:0] dc_nx  [NW+1];
  logic [NW-1:0] dc_ny  [NW+1];
  logic [W+1:0]  dc_rx  [NW+1];
  logic [W+1:0]  dc_ry  [NW+1];
  logic [NW-1:0] dc_qx  [NW+1];
  logic [NW-1:0] dc_qy  [NW+1];
  logic [PD-1:0] dc_sd  [NW+1];

  assign dc_v[0]  = vd_q;
  assign dc_dv[0] = dv_q;
  assign dc_nx[0] = nx_q;
  assign dc_ny[0] = ny_q;
  assign dc_rx[0] = '0;
  assign dc_ry[0] = '0;
  assign dc_qx[0] = '0;
  assign dc_qy[0] = '0;
  assign dc_sd[0] = sd_q;

  for (genvar k = 0; k < NW; k++) begin : g_div
    cpp_div_cell #(
      .W  (W),
      .I  (NW - 1 - k),
      .PW (PD)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dc_v[k]),
      .dv_i    (dc_dv[k]),
      .num_x_i (dc_nx[k]),
      .num_y_i (dc_ny[k]),
      .rem_x_i (dc_rx[k]),
      .rem_y_i (dc_ry[k]),
      .quo_x_i (dc_qx[k]),
      .quo_y_i (dc_qy[k]),
      .side_i  (dc_sd[k]),
      .valid_o (dc_v[k+1]),
      .dv_o    (dc_dv[k+1]),
      .num_x_o (dc_nx[k+1]),
      .num_y_o (dc_ny[k+1]),
      .rem_x_o (dc_rx[k+1]),
      .rem_y_o (dc_ry[k+1]),
      .quo_x_o (dc_qx[k+1]),
      .quo_y_o (dc_qy[k+1]),
      .side_o  (dc_sd[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: saturate, apply the sign, force zeros on a zero divisor.
  // --------------------------------------------------------------------------
  logic          fneg_x, fneg_y, ffault;
  logic [W-1:0]  fz;
  logic [NW-1:0] lim_x, lim_y, sat_x, sat_y;
  logic [W-1:0]  res_x, res_y;
  cpp_pkg::proj_t out_q;

  always_comb begin
    {fneg_x, fneg_y, ffault, fz} = dc_sd[NW];
    lim_x = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}} - {{(NW-1){1'b0}}, !fneg_x};
    lim_y = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}} - {{(NW-1){1'b0}}, !fneg_y};
    sat_x = (dc_qx[NW] > lim_x) ? lim_x : dc_qx[NW];
    sat_y = (dc_qy[NW] > lim_y) ? lim_y : dc_qy[NW];
    res_x = fneg_x ? (-sat_x[W-1:0]) : sat_x[W-1:0];
    res_y = fneg_y ? (-sat_y[W-1:0]) : sat_y[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dc_v[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.proj_x    <= ffault ? '0 : res_x;
      out_q.proj_y    <= ffault ? '0 : res_y;
      out_q.proj_z    <= fz;
      out_q.div_fault <= ffault;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
